@@ hdl/lpc_pkg.sv @@
// Package for the LRU page cache slot manager: types, op codes, sizes.
package lpc_pkg;
    localparam int NUM_SLOTS_DEF = 16;
    localparam int PAGE_W        = 32;
    localparam int SLOT_W        = 4;
    localparam int OP_W          = 3;

    localparam logic [OP_W-1:0] OP_ACCESS = 3'd0;
    localparam logic [OP_W-1:0] OP_DIRTY  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSTALL = 3'd2;
    localparam logic [OP_W-1:0] OP_COMMIT = 3'd3;
    localparam logic [OP_W-1:0] OP_INVAL  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] page;
    } t_in;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              fill;
        logic              writeback;
        logic [PAGE_W-1:0] wb_page;
        logic [SLOT_W-1:0] wb_slot;
        logic              last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input beat
        logic lookup;   // register match / free / lru search
        logic access;   // apply access update, emit result
        logic scan;     // commit: examine slot at scan index
        logic inval;    // clear all
        logic other;    // emit empty result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_access;
        logic is_commit;
        logic is_inval;
        logic scan_done;
    } t_sts;
endpackage

@@ hdl/lru_page_cache_slot_manager.sv @@
// Top level: LRU page cache slot manager.
// Access ops: lookup registered in decode; access updates and registers the result.
// Commit: one slot examined per cycle by the scan counter. New ops wait for idle.
// Invalidate and unused ops: empty result from decode. Results cannot be stalled.
// Synchronous active-low reset empties the cache and idles the controller.
module lru_page_cache_slot_manager
    import lpc_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_strobe,
    output t_out o_res
);
    t_cmd w_cmd;
    t_sts w_sts;

    lpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(busy)
    );

    lpc_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_strobe(o_strobe), .o_res(o_res)
    );
endmodule

@@ hdl/lpc_datapath.sv @@
// Datapath: slot tags, valid/dirty bits, LRU age counters, result register.
module lpc_datapath
    import lpc_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_strobe,
    output t_out o_res
);
    localparam int IW = $clog2(NUM_SLOTS);

    logic [PAGE_W-1:0] r_tag [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid, r_dirty;
    logic [NUM_SLOTS-1:0] n_valid, n_dirty;
    // age rank: 0 = MRU; valid slots hold distinct ranks 0..count-1
    logic [IW-1:0] r_age [NUM_SLOTS];
    t_in r_req;
    logic [IW-1:0] r_idx, n_idx;
    logic r_hit;
    logic [IW-1:0] r_sel;
    logic [IW:0] r_scan;
    logic r_any;
    logic r_strobe, n_strobe;
    t_out r_res, n_res;

    logic [NUM_SLOTS-1:0] w_match, w_free, w_lru;
    logic [NUM_SLOTS-1:0] w_rest;
    logic w_hitc, w_freec;
    logic [IW-1:0] w_hidx, w_fidx, w_lidx, w_old;
    logic [IW-1:0] w_scan_i;
    logic w_scan_end;

    always_comb begin
        w_hitc = 1'b0; w_freec = 1'b0;
        w_hidx = '0; w_fidx = '0; w_lidx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_match[i] = r_valid[i] && (r_tag[i] == r_req.page);
            w_free[i]  = !r_valid[i];
            w_lru[i]   = r_valid[i] && (r_age[i] == IW'(NUM_SLOTS - 1));
        end
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (w_match[i]) begin w_hitc = 1'b1; w_hidx = IW'(i); end
            if (w_free[i]) begin w_freec = 1'b1; w_fidx = IW'(i); end
            if (w_lru[i]) w_lidx = IW'(i);
        end
    end

    assign w_scan_i = r_scan[IW-1:0];
    assign w_scan_end = r_scan == (IW+1)'(NUM_SLOTS);
    assign w_old = r_age[r_idx];
    // dirty slots above the one being scanned
    assign w_rest = (r_valid & r_dirty) >> (r_scan + (IW+1)'(1));

    always_comb begin
        n_idx = w_hitc ? w_hidx : (w_freec ? w_fidx : w_lidx);
    end

    always_comb begin
        n_valid  = r_valid;
        n_dirty  = r_dirty;
        n_strobe = 1'b0;
        n_res    = r_res;
        if (i_cmd.access) begin
            n_valid[r_idx] = 1'b1;
            n_dirty[r_idx] = (r_req.op != OP_ACCESS) || (r_hit && r_dirty[r_idx]);
            n_strobe = 1'b1;
            n_res = '0;
            n_res.hit = r_hit;
            n_res.slot = SLOT_W'(r_sel);
            n_res.fill = !r_hit && (r_req.op != OP_INSTALL);
            n_res.last = 1'b1;
            if (!r_hit && r_valid[r_idx] && r_dirty[r_idx]) begin
                n_res.writeback = 1'b1;
                n_res.wb_page = r_tag[r_idx];
                n_res.wb_slot = SLOT_W'(r_idx);
            end
        end
        if (i_cmd.scan) begin
            if (w_scan_end) begin
                if (!r_any) begin
                    n_strobe = 1'b1;
                    n_res = '0;
                    n_res.last = 1'b1;
                end
            end else if (r_valid[w_scan_i] && r_dirty[w_scan_i]) begin
                n_dirty[w_scan_i] = 1'b0;
                n_strobe = 1'b1;
                n_res = '0;
                n_res.writeback = 1'b1;
                n_res.wb_page = r_tag[w_scan_i];
                n_res.wb_slot = SLOT_W'(w_scan_i);
                n_res.last = w_rest == '0;
            end
        end
        if (i_cmd.other || i_cmd.inval) begin
            n_strobe = 1'b1;
            n_res = '0;
            n_res.last = 1'b1;
        end
        if (!i_rst_n || i_cmd.inval) begin
            n_valid = '0;
            n_dirty = '0;
        end
        if (!i_rst_n) n_strobe = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in;
            r_scan <= '0;
            r_any <= 1'b0;
        end
        if (i_cmd.lookup) begin
            r_idx <= n_idx;
            r_hit <= w_hitc;
            r_sel <= n_idx;
        end
        if (i_cmd.access) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (IW'(i) == r_idx) r_age[i] <= '0;
                else if (r_valid[i] && (!r_valid[r_idx] || r_age[i] < w_old))
                    r_age[i] <= r_age[i] + 1'b1;
            end
            r_tag[r_idx] <= r_req.page;
        end
        if (i_cmd.scan && !w_scan_end) begin
            r_scan <= r_scan + 1'b1;
            if (r_valid[w_scan_i] && r_dirty[w_scan_i]) r_any <= 1'b1;
        end
        r_valid  <= n_valid;
        r_dirty  <= n_dirty;
        r_strobe <= n_strobe;
        r_res    <= n_res;
    end

    assign o_sts.is_access = r_req.op <= OP_INSTALL;
    assign o_sts.is_commit = r_req.op == OP_COMMIT;
    assign o_sts.is_inval  = r_req.op == OP_INVAL;
    assign o_sts.scan_done = w_scan_end;
    assign o_strobe = r_strobe;
    assign o_res = r_res;
endmodule

@@ hdl/lpc_ctrl.sv @@
// Controller state machine sequencing lookup, update, commit scan and invalidate.
module lpc_ctrl
    import lpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_ACCESS = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_access) begin
                    o_cmd.lookup = 1'b1;
                    n_state = S_ACCESS;
                end else if (i_sts.is_commit) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.inval = i_sts.is_inval;
                    o_cmd.other = !i_sts.is_inval;
                    n_state = S_IDLE;
                end
            end
            S_ACCESS: begin
                o_cmd.access = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;
endmodule

@@ hdl/lpc_checker.sv @@
// Port-level checker for the LRU page cache slot manager.
module lpc_checker
    import lpc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_out o_res
);
    a_wb_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.writeback && o_res.fill |-> o_res.wb_slot == o_res.slot)
        else $error("writeback slot differs from fill slot");
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.hit |-> !o_res.fill && !o_res.writeback)
        else $error("hit with fill or writeback");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && $past(!busy) && $past(!start) |-> !o_strobe)
        else $error("result strobe while idle");
endmodule

bind lru_page_cache_slot_manager lpc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_res(o_res)
);
